### design/esc_pkg.sv
// Shared types, constants and lookup functions for the epoch seconds to calendar converter.
package esc_pkg;

  localparam int unsigned SecWidth   = 32;
  localparam int unsigned OutWidth   = 48;
  localparam int unsigned QuoWidth   = 16;
  localparam int unsigned DayWidth   = 17;
  localparam int unsigned YearWidth  = 12;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // ceil(2^35 / 675), ceil(2^21 / 225), ceil(2^14 / 15), ceil(2^19 / 7)
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  localparam logic [16:0] WDAY_RECIP = 17'd74899;

  localparam logic [YearWidth-1:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [1:0]           EPOCH_YMOD4    = 2'd2;
  localparam logic [YearWidth-1:0] NOLEAP_CENTURY = 12'd2100;
  localparam logic [3:0]           FIRST_MONTH    = 4'd1;
  localparam logic [3:0]           LAST_MONTH     = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY,
    ST_DAY_REM,
    ST_HOUR,
    ST_HOUR_REM,
    ST_MIN,
    ST_MIN_REM,
    ST_YEAR_LD,
    ST_YEAR,
    ST_MONTH_LD,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_DAY,
    OP_REM_DAY,
    OP_DIV_HOUR,
    OP_REM_HOUR,
    OP_DIV_MIN,
    OP_REM_MIN,
    OP_YEAR_INIT,
    OP_YEAR_STEP,
    OP_MONTH_INIT,
    OP_MONTH_STEP,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } dp_sts_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] weekday_of(input logic [2:0] residue);
    logic [2:0] wd;
    unique case (residue)
      3'd0:    wd = 3'd4;
      3'd1:    wd = 3'd5;
      3'd2:    wd = 3'd6;
      3'd3:    wd = 3'd0;
      3'd4:    wd = 3'd1;
      3'd5:    wd = 3'd2;
      3'd6:    wd = 3'd3;
      default: wd = 3'd0;
    endcase
    return wd;
  endfunction

endpackage

### design/epoch_seconds_to_calendar.sv
// Top level of the epoch seconds to calendar converter.
//
//  channel  dir  word                                                    handshake
//  in_      in   seconds [31:0]                                          tvalid/tready
//  out_     out  year, month, day_of_month, hour, minute, second, wkday  tvalid/tready
//
//  One word at a time: the time from acceptance to out_tvalid grows with the year and month,
//  set by the year and month walks after six reciprocal-multiply divide and remainder steps.
//  The result sits in an output register; a new word is accepted while it waits.
//  A stalled result holds the converter in its final state until out_tready.
//  Synchronous active-low reset clears the controller and drops out_tvalid.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // seconds[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // year[11:0], month[15:12], day_of_month[20:16],
                                  // hour[25:21], minute[31:26], second_of_minute[37:32],
                                  // weekday[40:38], zero[47:41]
);

  esc_pkg::dp_cmd_t cmd;
  esc_pkg::dp_sts_t sts;

  esc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  esc_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .seconds  (in_tdata),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule

### design/esc_dp.sv
// Datapath: reciprocal-multiply divides, year and month walkers, output word register.
module esc_dp (
  input  logic                          clk,
  input  esc_pkg::dp_cmd_t              cmd,
  input  logic [esc_pkg::SecWidth-1:0]  seconds,
  output esc_pkg::dp_sts_t              sts,
  output logic [esc_pkg::OutWidth-1:0]  out_data
);

  logic [esc_pkg::SecWidth-1:0]  rem_r, rem_nxt;
  logic [13:0]                   quo_r, quo_nxt;
  logic [esc_pkg::QuoWidth-1:0]  days_r, days_nxt;
  logic [4:0]                    hour_r, hour_nxt;
  logic [5:0]                    minute_r, minute_nxt;
  logic [5:0]                    sec_r, sec_nxt;
  logic [2:0]                    wday_r, wday_nxt;
  logic [esc_pkg::DayWidth-1:0]  day_r, day_nxt;
  logic [esc_pkg::YearWidth-1:0] year_r, year_nxt;
  logic [1:0]                    ymod4_r, ymod4_nxt;
  logic [3:0]                    month_r, month_nxt;
  logic [esc_pkg::OutWidth-1:0]  out_r, out_nxt;

  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [50:0] day_prod;
  logic [32:0] day_back;
  logic [32:0] wday_prod;
  logic [26:0] hour_prod;
  logic [16:0] hour_back;
  logic [20:0] min_prod;
  logic [11:0] min_back;

  always_comb begin
    leap = (ymod4_r == 2'd0) && (year_r != esc_pkg::NOLEAP_CENTURY);
    ylen = leap ? 9'd366 : 9'd365;
    mlen = esc_pkg::month_days(month_r, leap);
    sts.year_done  = day_r <= {8'd0, ylen};
    sts.month_done = (month_r == esc_pkg::LAST_MONTH) || (day_r <= {12'd0, mlen});
  end

  always_comb begin
    day_prod  = 51'(rem_r[31:7]) * 51'(esc_pkg::DAY_RECIP);
    day_back  = 33'(days_r) * 33'(esc_pkg::SECS_PER_DAY);
    wday_prod = 33'(days_r) * 33'(esc_pkg::WDAY_RECIP);
    hour_prod = 27'(rem_r[16:4]) * 27'(esc_pkg::HOUR_RECIP);
    hour_back = 17'(hour_r) * 17'(esc_pkg::SECS_PER_HOUR);
    min_prod  = 21'(rem_r[11:2]) * 21'(esc_pkg::MIN_RECIP);
    min_back  = 12'(minute_r) * 12'(esc_pkg::SECS_PER_MIN);
  end

  always_comb begin
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    days_nxt   = days_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    sec_nxt    = sec_r;
    wday_nxt   = wday_r;
    day_nxt    = day_r;
    year_nxt   = year_r;
    ymod4_nxt  = ymod4_r;
    month_nxt  = month_r;
    out_nxt    = out_r;
    unique case (cmd.op)
      esc_pkg::OP_NONE: begin
      end
      esc_pkg::OP_LOAD: begin
        rem_nxt = seconds;
      end
      esc_pkg::OP_DIV_DAY: begin
        days_nxt = day_prod[50:35];
      end
      esc_pkg::OP_REM_DAY: begin
        rem_nxt = rem_r - day_back[31:0];
        quo_nxt = wday_prod[32:19];
      end
      esc_pkg::OP_DIV_HOUR: begin
        hour_nxt = hour_prod[25:21];
      end
      esc_pkg::OP_REM_HOUR: begin
        rem_nxt = rem_r - {15'd0, hour_back};
      end
      esc_pkg::OP_DIV_MIN: begin
        minute_nxt = min_prod[19:14];
      end
      esc_pkg::OP_REM_MIN: begin
        sec_nxt = rem_r[5:0] - min_back[5:0];
      end
      esc_pkg::OP_YEAR_INIT: begin
        // days - 7q equals days + q modulo 8
        wday_nxt  = esc_pkg::weekday_of(days_r[2:0] + quo_r[2:0]);
        day_nxt   = {1'b0, days_r} + 17'd1;
        year_nxt  = esc_pkg::EPOCH_YEAR;
        ymod4_nxt = esc_pkg::EPOCH_YMOD4;
      end
      esc_pkg::OP_YEAR_STEP: begin
        day_nxt   = day_r - {8'd0, ylen};
        year_nxt  = year_r + 12'd1;
        ymod4_nxt = ymod4_r + 2'd1;
      end
      esc_pkg::OP_MONTH_INIT: begin
        month_nxt = esc_pkg::FIRST_MONTH;
      end
      esc_pkg::OP_MONTH_STEP: begin
        day_nxt   = day_r - {12'd0, mlen};
        month_nxt = month_r + 4'd1;
      end
      esc_pkg::OP_OUT: begin
        out_nxt = {7'd0, wday_r, sec_r, minute_r, hour_r, day_r[4:0], month_r, year_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    days_r   <= days_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    sec_r    <= sec_nxt;
    wday_r   <= wday_nxt;
    day_r    <= day_nxt;
    year_r   <= year_nxt;
    ymod4_r  <= ymod4_nxt;
    month_r  <= month_nxt;
    out_r    <= out_nxt;
  end

  assign out_data = out_r;

endmodule

### design/esc_ctrl.sv
// Controller: sequences the constant divides, year and month walks and owns the handshakes.
module esc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  esc_pkg::dp_sts_t sts,
  output esc_pkg::dp_cmd_t cmd
);

  esc_pkg::state_t               state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= esc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = esc_pkg::OP_NONE;
    unique case (state_r)
      esc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = esc_pkg::OP_LOAD;
          state_nxt = esc_pkg::ST_DAY;
        end
      end
      esc_pkg::ST_DAY: begin
        cmd.op    = esc_pkg::OP_DIV_DAY;
        state_nxt = esc_pkg::ST_DAY_REM;
      end
      esc_pkg::ST_DAY_REM: begin
        cmd.op    = esc_pkg::OP_REM_DAY;
        state_nxt = esc_pkg::ST_HOUR;
      end
      esc_pkg::ST_HOUR: begin
        cmd.op    = esc_pkg::OP_DIV_HOUR;
        state_nxt = esc_pkg::ST_HOUR_REM;
      end
      esc_pkg::ST_HOUR_REM: begin
        cmd.op    = esc_pkg::OP_REM_HOUR;
        state_nxt = esc_pkg::ST_MIN;
      end
      esc_pkg::ST_MIN: begin
        cmd.op    = esc_pkg::OP_DIV_MIN;
        state_nxt = esc_pkg::ST_MIN_REM;
      end
      esc_pkg::ST_MIN_REM: begin
        cmd.op    = esc_pkg::OP_REM_MIN;
        state_nxt = esc_pkg::ST_YEAR_LD;
      end
      esc_pkg::ST_YEAR_LD: begin
        cmd.op    = esc_pkg::OP_YEAR_INIT;
        state_nxt = esc_pkg::ST_YEAR;
      end
      esc_pkg::ST_YEAR: begin
        if (sts.year_done) begin
          state_nxt = esc_pkg::ST_MONTH_LD;
        end else begin
          cmd.op = esc_pkg::OP_YEAR_STEP;
        end
      end
      esc_pkg::ST_MONTH_LD: begin
        cmd.op    = esc_pkg::OP_MONTH_INIT;
        state_nxt = esc_pkg::ST_MONTH;
      end
      esc_pkg::ST_MONTH: begin
        if (sts.month_done) begin
          state_nxt = esc_pkg::ST_DONE;
        end else begin
          cmd.op = esc_pkg::OP_MONTH_STEP;
        end
      end
      esc_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = esc_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = esc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = esc_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == esc_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == esc_pkg::ST_DAY))
    else $error("accepted word did not start the day division");

  a_day_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esc_pkg::ST_DAY) |=> (state_r == esc_pkg::ST_DAY_REM))
    else $error("day division ran the wrong number of steps");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esc_pkg::ST_DONE && (!out_valid_r || out_tready))
      |=> (out_valid_r && state_r == esc_pkg::ST_IDLE))
    else $error("finished result not presented");

  a_month_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esc_pkg::ST_MONTH && !sts.month_done) |=> (state_r == esc_pkg::ST_MONTH))
    else $error("month walk left early");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the epoch seconds to calendar converter: scoreboard, drivers and run control.
module tb_top;

  typedef struct packed {
    logic [6:0]  pad;
    logic [2:0]  weekday;
    logic [5:0]  sec_of_min;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [11:0] year;
  } calendar_t;

  class calendar_scoreboard;
    calendar_t   due_q[$];
    int unsigned errors;

    function calendar_t to_calendar(logic [31:0] secs);
      calendar_t   cal;
      int unsigned days, day, yr, mo, span;
      bit          leap;
      days = secs / 32'd86400;
      day  = days + 1;
      yr   = 1970;
      mo   = 1;
      forever begin
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        span = leap ? 366 : 365;
        if (day <= span) break;
        day -= span;
        yr++;
      end
      while (mo < 12) begin
        case (mo)
          2:          span = leap ? 29 : 28;
          4, 6, 9, 11: span = 30;
          default:    span = 31;
        endcase
        if (day <= span) break;
        day -= span;
        mo++;
      end
      cal.pad        = '0;
      cal.weekday    = 3'((days + 4) % 7);
      cal.sec_of_min = 6'(secs % 60);
      cal.minute     = 6'((secs / 60) % 60);
      cal.hour       = 5'((secs / 3600) % 24);
      cal.mday       = 5'(day);
      cal.month      = 4'(mo);
      cal.year       = 12'(yr);
      return cal;
    endfunction

    function void note_seconds(logic [31:0] secs);
      due_q.push_back(to_calendar(secs));
    endfunction

    function void flag(string what, longint unsigned want, longint unsigned got);
      errors++;
      if (errors <= 10)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_word(logic [47:0] word);
      calendar_t got, want;
      got = word;
      if (due_q.size() == 0) begin
        flag("unexpected word", 0, word);
        return;
      end
      want = due_q.pop_front();
      if (got.year != want.year)             flag("year", want.year, got.year);
      if (got.month != want.month)           flag("month", want.month, got.month);
      if (got.mday != want.mday)             flag("day_of_month", want.mday, got.mday);
      if (got.hour != want.hour)             flag("hour", want.hour, got.hour);
      if (got.minute != want.minute)         flag("minute", want.minute, got.minute);
      if (got.sec_of_min != want.sec_of_min) flag("second", want.sec_of_min, got.sec_of_min);
      if (got.weekday != want.weekday)       flag("weekday", want.weekday, got.weekday);
      if (got.pad != want.pad)               flag("padding", want.pad, got.pad);
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  localparam int unsigned RandomWords = 750;

  localparam logic [31:0] EDGE_SECONDS [23] = '{
    32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd68169600, 32'd94694399, 32'd94694400, 32'd946684799, 32'd946684800,
    32'd951782400, 32'd951868799, 32'd2147483647, 32'd2147483648, 32'd4107456000,
    32'd4107542399, 32'd4107542400, 32'hAAAA_AAAA, 32'h5555_5555, 32'd4291747200
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  bit          steady;
  int unsigned hold_len;

  calendar_scoreboard sb = new();

  epoch_seconds_to_calendar u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
    if (rst_n && in_tvalid && in_tready) sb.note_seconds(in_tdata);
  end

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic send_seconds(input logic [31:0] secs);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    do @(posedge clk); while (!in_tready);
  endtask

  // Result side: stall per word, or hold off for a long stretch on request.
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_gap();
      if (hold_len != 0) begin
        stall    = hold_len;
        hold_len = 0;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    logic [31:0] secs;
    longint      picked;
    longint      year_days;
    int unsigned yr;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    steady    = 1'b0;
    hold_len  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (EDGE_SECONDS[i]) send_seconds(EDGE_SECONDS[i]);

    for (int n = 0; n < RandomWords; n++) begin
      if (n % 150 == 0) steady = ((n / 150) % 2) == 1;
      if (n == 300) hold_len = 800;
      if (n == 520) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 3))
        0: secs = $urandom();
        1: begin
          picked = longint'($urandom_range(0, 49710)) * 86400;
          picked += $urandom_range(0, 1) ? $urandom_range(0, 2) : 86397 + $urandom_range(0, 2);
          secs = (picked > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : picked[31:0];
        end
        2: begin
          yr        = $urandom_range(1971, 2106);
          year_days = 0;
          for (int y = 1970; y < yr; y++)
            year_days += (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 366 : 365;
          picked = year_days * 86400 + longint'($urandom_range(0, 6)) - 3;
          secs = (picked > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : picked[31:0];
        end
        default: secs = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
      endcase
      send_seconds(secs);
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

### files.f
design/esc_pkg.sv
design/esc_dp.sv
design/esc_ctrl.sv
design/epoch_seconds_to_calendar.sv
verif/tb_top.sv
